>>> hw/rtl/trimmed_window_mean_filter_core_macros.svh
// Assertion macros shared by the trimmed window mean filter RTL.
`ifndef TRIMMED_WINDOW_MEAN_FILTER_CORE_MACROS_SVH
`define TRIMMED_WINDOW_MEAN_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/twm_pkg.sv
// Shared constants, types and index helpers of the trimmed window mean filter.
`default_nettype none
package twm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int HALF_MAX    = 15;
  localparam int STORE_DEPTH = 2 * HALF_MAX + 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int HALF_W      = $clog2(HALF_MAX + 1);
  localparam int POS_W       = 16;
  localparam int WLEN_W      = 5;
  localparam int LIMIT_W     = 16;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W       = SAMPLE_BITS + CNT_W + 1;
  localparam int NUM_W       = SUM_W;
  localparam int DEN_W       = CNT_W + 1;
  localparam int DCNT_W      = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 2'd2;

  localparam logic [WLEN_W-1:0]  WLEN_RESET  = 5'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32768;
  localparam logic [POS_W-1:0]   RLEN_RESET  = 16'd1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic setup;
    logic scan;
    logic prep;
    logic div_step;
    logic emit;
  } twm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_output;
    logic scan_last;
    logic div_last;
    logic out_free;
    logic last_q;
  } twm_stat_t;

  // Circular index minus a small offset, modulo the store depth.
  function automatic logic [IDX_W-1:0] idx_sub(input logic [IDX_W-1:0] a,
                                               input logic [HALF_W-1:0] b);
    logic [IDX_W:0] ax;
    logic [IDX_W:0] bx;
    logic [IDX_W:0] r;
    ax = {1'b0, a};
    bx = (IDX_W + 1)'(b);
    if (ax >= bx) r = ax - bx;
    else r = ax + (IDX_W + 1)'(STORE_DEPTH) - bx;
    return r[IDX_W-1:0];
  endfunction

  // Circular index plus one, modulo the store depth.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
    if (a == IDX_W'(STORE_DEPTH - 1)) return '0;
    return a + 1'b1;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/twm_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module twm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/twm_dp.sv
// Datapath: configuration, sample store, window scan, serial divider, output register.
`default_nettype none
module twm_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [twm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [twm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic signed [twm_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic                                 out_ready,
  input  wire twm_pkg::twm_cmd_t                    cmd,
  output twm_pkg::twm_stat_t                        stat,
  output logic                                      out_valid,
  output logic signed [twm_pkg::SAMPLE_BITS-1:0]    filtered,
  output logic [twm_pkg::POS_W-1:0]                 position,
  output logic                                      record_end,
  output logic                                      run_end
);
  import twm_pkg::*;

  // Configuration registers.
  logic [WLEN_W-1:0]  wlen;
  logic [LIMIT_W-1:0] ilimit;
  logic [POS_W-1:0]   rlen;

  // Record position of the next sample and its store index.
  logic [POS_W-1:0] sample_count;
  logic [IDX_W-1:0] p_mod;

  // Output sequencing.
  logic [POS_W-1:0] q;
  logic [IDX_W-1:0] q_mod;
  logic [POS_W-1:0] q_last;
  logic [POS_W-1:0] end_last;
  logic             flush_r;

  // Window scan.
  logic [POS_W-1:0] t;
  logic [IDX_W-1:0] t_mod;
  logic [POS_W-1:0] hi;
  logic             rd_valid_d;
  logic             rd_centre_d;
  logic [SAMPLE_BITS-1:0] rd_data;

  // Accumulators.
  logic signed [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]              cnt;
  logic signed [SAMPLE_BITS-1:0] mn;
  logic signed [SAMPLE_BITS-1:0] mx;
  logic signed [SAMPLE_BITS-1:0] centre;

  // Divider.
  logic [NUM_W-1:0]  dnum;
  logic [DEN_W-1:0]  dden;
  logic [DEN_W-1:0]  drem;
  logic [DCNT_W-1:0] dcnt;
  logic              neg;
  logic              use_mean;

  // Effective settings.
  logic [POS_W-1:0]  n_eff;
  logic [WLEN_W-1:0] len_eff;
  logic [WLEN_W-1:0] h_raw;
  logic [HALF_W-1:0] h;
  logic              enabled;

  always_comb begin
    n_eff   = (rlen == '0) ? POS_W'(1) : rlen;
    len_eff = (wlen == '0) ? WLEN_W'(1) : wlen;
    h_raw   = (len_eff - 1'b1) >> 1;
    h       = (h_raw > WLEN_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : h_raw[HALF_W-1:0];
    enabled = n_eff > POS_W'({len_eff - 1'b1, 1'b0});
  end

  // Item arrival decode.
  logic             flush;
  logic [HALF_W-1:0] d0;
  logic [POS_W-1:0]  q_first;

  always_comb begin
    flush   = ({1'b0, sample_count} + 1'b1) >= {1'b0, n_eff};
    d0      = (sample_count >= POS_W'(h)) ? h : sample_count[HALF_W-1:0];
    q_first = sample_count - POS_W'(d0);
  end

  // Window bounds for the current output position.
  logic [HALF_W-1:0] d1;
  logic [POS_W:0]    qh;

  always_comb begin
    d1 = (q >= POS_W'(h)) ? h : q[HALF_W-1:0];
    qh = {1'b0, q} + (POS_W + 1)'(h);
  end

  // Sample classification of the word coming out of the store.
  logic signed [SAMPLE_BITS-1:0] v;
  logic [SAMPLE_BITS:0]          vext;
  logic [SAMPLE_BITS:0]          vmag;
  logic                          v_ok;

  always_comb begin
    v    = signed'(rd_data);
    vext = {rd_data[SAMPLE_BITS-1], rd_data};
    vmag = rd_data[SAMPLE_BITS-1] ? (~vext + 1'b1) : vext;
    v_ok = vmag < (SAMPLE_BITS + 1)'(ilimit);
  end

  // Divider setup terms.
  logic signed [SUM_W-1:0] trimmed;
  logic [SUM_W-1:0]        tmag;
  logic [CNT_W-1:0]        dsub;

  always_comb begin
    trimmed = sum - SUM_W'(mn) - SUM_W'(mx);
    tmag    = trimmed[SUM_W-1] ? (~trimmed + 1'b1) : trimmed;
    dsub    = cnt - CNT_W'(2);
  end

  // One restoring division step.
  logic [DEN_W:0] rem_sh;
  logic           rem_ge;

  always_comb begin
    rem_sh = {drem, dnum[NUM_W-1]};
    rem_ge = rem_sh >= {1'b0, dden};
  end

  // Rounded quotient with sign restored.
  logic [NUM_W-1:0] qsigned;

  always_comb begin
    qsigned = neg ? (~dnum + 1'b1) : dnum;
  end

  always_comb begin
    stat.has_output = flush || (sample_count >= POS_W'(h));
    stat.scan_last  = (t == hi);
    stat.div_last   = (dcnt == DCNT_W'(1));
    stat.out_free   = !out_valid || out_ready;
    stat.last_q     = (q == q_last);
  end

  twm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (p_mod),
    .wr_data (sample),
    .rd_en   (cmd.scan),
    .rd_addr (t_mod),
    .rd_data (rd_data)
  );

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      wlen         <= WLEN_RESET;
      ilimit       <= LIMIT_RESET;
      rlen         <= RLEN_RESET;
      sample_count <= '0;
      p_mod        <= '0;
      out_valid    <= 1'b0;
      rd_valid_d   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LENGTH: wlen   <= cfg_data[WLEN_W-1:0];
          REG_INVALID_LIMIT: ilimit <= cfg_data[LIMIT_W-1:0];
          REG_RECORD_LENGTH: rlen   <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        sample_count <= flush ? '0 : sample_count + 1'b1;
        p_mod        <= flush ? '0 : idx_inc(p_mod);
      end
      rd_valid_d <= cmd.scan;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q        <= q_first;
      q_mod    <= idx_sub(p_mod, d0);
      q_last   <= flush ? sample_count : q_first;
      end_last <= flush ? sample_count : n_eff - 1'b1;
      flush_r  <= flush;
    end

    if (cmd.setup) begin
      t     <= q - POS_W'(d1);
      t_mod <= idx_sub(q_mod, d1);
      hi    <= (qh > {1'b0, end_last}) ? end_last : qh[POS_W-1:0];
      sum   <= '0;
      cnt   <= '0;
    end else if (rd_valid_d && v_ok) begin
      if (cnt == '0 || v < mn) mn <= v;
      if (cnt == '0 || v > mx) mx <= v;
      sum <= sum + SUM_W'(v);
      cnt <= cnt + 1'b1;
    end

    if (cmd.scan) begin
      t           <= t + 1'b1;
      t_mod       <= idx_inc(t_mod);
      rd_centre_d <= (t == q);
    end

    if (rd_valid_d && rd_centre_d) begin
      centre <= v;
    end

    if (cmd.prep) begin
      neg      <= trimmed[SUM_W-1];
      dnum     <= {tmag[SUM_W-2:0], 1'b0} + NUM_W'(dsub);
      dden     <= {dsub, 1'b0};
      drem     <= '0;
      dcnt     <= DCNT_W'(NUM_W);
      use_mean <= enabled && (cnt > CNT_W'(2));
    end

    if (cmd.div_step) begin
      dnum <= {dnum[NUM_W-2:0], rem_ge};
      drem <= rem_ge ? DEN_W'(rem_sh - {1'b0, dden}) : rem_sh[DEN_W-1:0];
      dcnt <= dcnt - 1'b1;
    end

    if (cmd.emit) begin
      filtered   <= use_mean ? signed'(qsigned[SAMPLE_BITS-1:0]) : centre;
      position   <= q;
      record_end <= flush_r && (q == q_last);
      run_end    <= (q == q_last);
      q          <= q + 1'b1;
      q_mod      <= idx_inc(q_mod);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/twm_ctrl.sv
// Controller state machine sequencing window scan, divide and output hand-off.
`default_nettype none
module twm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire twm_pkg::twm_stat_t stat,
  output twm_pkg::twm_cmd_t       cmd
);
  import twm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_SETTLE,
    S_PREP,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && stat.has_output) state <= S_SETUP;
        end
        S_SETUP:  state <= S_SCAN;
        S_SCAN: begin
          if (stat.scan_last) state <= S_SETTLE;
        end
        S_SETTLE: state <= S_PREP;
        S_PREP:   state <= S_DIV;
        S_DIV: begin
          if (stat.div_last) state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) state <= stat.last_q ? S_IDLE : S_SETUP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.accept   = in_ready && in_valid;
    cmd.setup    = (state == S_SETUP);
    cmd.scan     = (state == S_SCAN);
    cmd.prep     = (state == S_PREP);
    cmd.div_step = (state == S_DIV);
    cmd.emit     = (state == S_EMIT) && stat.out_free;
  end

endmodule
`default_nettype wire

>>> hw/rtl/trimmed_window_mean_filter_core.sv
// Top level of the trimmed window mean filter: controller, datapath and checks.
//
// Usage: samples enter one item at a time on the in_valid/in_ready channel;
// results leave on the out_valid/out_ready channel with filtered, position,
// record_end and run_end. Configuration is written through cfg_we, cfg_index
// and cfg_data (window length, invalid limit, record length) while idle.
// Each sample is stored in a 31-entry circular RAM. Once the window around a
// position is complete, the controller scans it through the RAM read port, one
// sample per cycle, then a restoring divider produces one quotient bit per
// cycle. The scan covers at most 2*h+1 samples. An item that yields no result
// leaves the block ready for the next item. The last sample of a record
// produces up to h+1 results back to back. in_ready is high only while no
// result of the previous item is still being computed; a finished result
// waits in the output register, and the next item is accepted meanwhile.
// When the receiver stalls, the block holds the result and waits before
// loading the next one. Reset clears the registers to their defaults,
// empties the output register and starts a new record at position 0.
`default_nettype none
`include "trimmed_window_mean_filter_core_macros.svh"
module trimmed_window_mean_filter_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [twm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [twm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [twm_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [twm_pkg::SAMPLE_BITS-1:0]      filtered,
  output logic [twm_pkg::POS_W-1:0]                   position,
  output logic                                        record_end,
  output logic                                        run_end
);
  import twm_pkg::*;

  twm_cmd_t  cmd;
  twm_stat_t stat;

  // The controller only sequences; all arithmetic and storage sit in the datapath.
  twm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  twm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .filtered   (filtered),
    .position   (position),
    .record_end (record_end),
    .run_end    (run_end)
  );

  // The controller never issues two datapath commands in the same cycle.
  `TWM_ASSERT_SAME(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd), "overlapping datapath commands")
  // A result is only loaded when the output register is free.
  `TWM_ASSERT_SAME(a_emit_free, clk, rst, cmd.emit, stat.out_free, "result loaded over a held one")
  // An item that yields no result leaves the block ready for the next one.
  `TWM_ASSERT_NEXT(a_quiet_item, clk, rst, cmd.accept && !stat.has_output, in_ready,
                   "block busy after an item without result")
  // An item that yields results blocks input until they are computed.
  `TWM_ASSERT_NEXT(a_busy_item, clk, rst, cmd.accept && stat.has_output, !in_ready,
                   "block ready while results are pending")

endmodule
`default_nettype wire
